// File: rtl/mcadc_pkg.sv
// ============================================================================
// mcadc_pkg - shared types and constants for the converter statistics block
// Field widths of the stream payloads, opcode codes and the queue item type.
// ============================================================================
package mcadc_pkg;

    // Payload field widths (fixed by the stream format)
    localparam int OPCODE_W       = 2;
    localparam int SAMPLE_FIELD_W = 12;
    localparam int SELECT_W       = 3;
    localparam int NEXT_CH_W      = 3;
    localparam int SUM_FIELD_W    = 40;
    localparam int COUNT_FIELD_W  = 24;
    localparam int ROUND_W        = 24;
    localparam int CFG_W          = 4;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 128;

    // Width used to compare channel numbers against the channel count
    localparam int CH_CMP_W = 5;

    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    // Defaults for the top-level parameters
    localparam int NUM_CHANNELS_DEF = 8;
    localparam int SAMPLE_BITS_DEF  = 12;
    localparam int SUM_BITS_DEF     = 40;
    localparam int COUNT_BITS_DEF   = 24;
    localparam int QUEUE_DEPTH_DEF  = 2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_SAMPLE    = 2'd0,
        OP_BOUNDARY  = 2'd1,
        OP_READ_SNAP = 2'd2,
        OP_READ_LIVE = 2'd3
    } op_t;

    // Classified item handed from front to back
    typedef struct packed {
        op_t                       op;
        logic [SAMPLE_FIELD_W-1:0] sample;
        logic [SELECT_W-1:0]       sel;
        logic                      sel_ok;
    } item_t;

    // Result beat, first field in the highest bits
    typedef struct packed {
        logic                      pad;
        logic [ROUND_W-1:0]        rounds_per_second;
        logic [SAMPLE_FIELD_W-1:0] last_sample;
        logic [COUNT_FIELD_W-1:0]  stat_count;
        logic [SUM_FIELD_W-1:0]    stat_sum;
        logic [SAMPLE_FIELD_W-1:0] stat_max;
        logic [SAMPLE_FIELD_W-1:0] stat_min;
        logic [NEXT_CH_W-1:0]      next_channel;
    } result_t;

endpackage

// File: rtl/multichannel_adc_statistics.sv
// ============================================================================
// multichannel_adc_statistics - round-robin per-channel converter statistics
// Live min/max/sum/count per channel, snapshot on second boundary, readback.
// ============================================================================
// Every input beat gives exactly one result beat. A beat can be taken each
// clock: the front classifies the beat and pushes it into a short queue, the
// back executes one queued item per cycle and holds the result in an output
// register, so throughput is one item per cycle while m_tready stays high.
// An input beat passes through the queue and then the output register.
// Opcodes: 0 credits sample_value to the current channel and advances the
// round-robin index; 1 copies all live statistics to the snapshot set,
// reports the completed rounds and clears the live set; 2 reads snapshot
// min/max/sum/count of channel_select; 3 reads the last sample and live
// count of channel_select. Selects at or above NUM_CHANNELS read zero. Sums,
// counts and the round counter saturate. channels_in_use is written on the
// cfg port; the user must write it only while the block is idle (not enforced
// by the block). 0 acts as 1 and values above NUM_CHANNELS act as NUM_CHANNELS.
// ============================================================================
module multichannel_adc_statistics
    import mcadc_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
    parameter int SUM_BITS     = SUM_BITS_DEF,
    parameter int COUNT_BITS   = COUNT_BITS_DEF,
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration: channels_in_use
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_W-1:0]     cfg_data,
    // input beats
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [11:0] sample_value, [14:12] channel_select
    input  logic [OPCODE_W-1:0]  s_tuser,   // [1:0] opcode
    // result beats
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // [2:0] next_channel, [14:3] stat_min,
                                            // [26:15] stat_max, [66:27] stat_sum,
                                            // [90:67] stat_count, [102:91] last_sample,
                                            // [126:103] rounds_per_second
);

    logic  push_valid, push_ready;
    item_t push_item;
    logic  q_valid, q_ready;
    item_t q_item;

    // Front: accept and classify
    mcadc_front #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    // Decoupling queue
    mcadc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    // Back: statistics state and result register
    mcadc_back #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .SUM_BITS     (SUM_BITS),
        .COUNT_BITS   (COUNT_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// File: rtl/mcadc_front.sv
// ============================================================================
// mcadc_front - input side of the converter statistics block
// Takes input beats, masks the sample and range-checks the channel select.
// ============================================================================
module mcadc_front
    import mcadc_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
)
(
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [OPCODE_W-1:0]  s_tuser,
    output logic                 push_valid,
    input  logic                 push_ready,
    output item_t                push_item
);

    localparam logic [SAMPLE_FIELD_W-1:0] SAMPLE_MASK =
        (SAMPLE_BITS >= SAMPLE_FIELD_W) ? '1 : SAMPLE_FIELD_W'((1 << SAMPLE_BITS) - 1);

    logic [SELECT_W-1:0] sel;

    assign sel        = s_tdata[SAMPLE_FIELD_W +: SELECT_W];
    assign s_tready   = push_ready;
    assign push_valid = s_tvalid;

    always_comb
    begin
        push_item.op     = op_t'(s_tuser);
        push_item.sample = s_tdata[SAMPLE_FIELD_W-1:0] & SAMPLE_MASK;
        push_item.sel    = sel;
        push_item.sel_ok = CH_CMP_W'(sel) < CH_CMP_W'(NUM_CHANNELS);
    end

endmodule

// File: rtl/mcadc_queue.sv
// ============================================================================
// mcadc_queue - short item queue between front and back
// Small FIFO of classified items; lets either side stall on its own.
// ============================================================================
module mcadc_queue
    import mcadc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    output logic  push_ready,
    input  item_t push_item,
    output logic  pop_valid,
    input  logic  pop_ready,
    output item_t pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    item_t            entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             push, pop;

    assign push_ready = (cnt_reg != FULL_CNT);
    assign pop_valid  = (cnt_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

    // Fill level never exceeds the depth
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= FULL_CNT)
        else $error("queue fill level above depth");

    // Pointers stay together with the fill level
    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0 || cnt_reg == FULL_CNT) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers out of step with fill level");

endmodule

// File: rtl/mcadc_back.sv
// ============================================================================
// mcadc_back - statistics state and result register
// Executes one queued item per cycle against the live and snapshot sets while m_tready does not stall.
// ============================================================================
module mcadc_back
    import mcadc_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
    parameter int SUM_BITS     = SUM_BITS_DEF,
    parameter int COUNT_BITS   = COUNT_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  item_t                q_item,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic [SAMPLE_BITS-1:0] live_min_reg [NUM_CHANNELS];
    logic [SAMPLE_BITS-1:0] live_min_next [NUM_CHANNELS];
    logic [SAMPLE_BITS-1:0] live_max_reg [NUM_CHANNELS];
    logic [SAMPLE_BITS-1:0] live_max_next [NUM_CHANNELS];
    logic [SUM_BITS-1:0]    live_sum_reg [NUM_CHANNELS];
    logic [SUM_BITS-1:0]    live_sum_next [NUM_CHANNELS];
    logic [COUNT_BITS-1:0]  live_cnt_reg [NUM_CHANNELS];
    logic [COUNT_BITS-1:0]  live_cnt_next [NUM_CHANNELS];
    logic [SAMPLE_BITS-1:0] snap_min_reg [NUM_CHANNELS];
    logic [SAMPLE_BITS-1:0] snap_min_next [NUM_CHANNELS];
    logic [SAMPLE_BITS-1:0] snap_max_reg [NUM_CHANNELS];
    logic [SAMPLE_BITS-1:0] snap_max_next [NUM_CHANNELS];
    logic [SUM_BITS-1:0]    snap_sum_reg [NUM_CHANNELS];
    logic [SUM_BITS-1:0]    snap_sum_next [NUM_CHANNELS];
    logic [COUNT_BITS-1:0]  snap_cnt_reg [NUM_CHANNELS];
    logic [COUNT_BITS-1:0]  snap_cnt_next [NUM_CHANNELS];
    logic [SAMPLE_BITS-1:0] latest_reg [NUM_CHANNELS];
    logic [SAMPLE_BITS-1:0] latest_next [NUM_CHANNELS];

    logic [CH_W-1:0]     cur_ch_reg, cur_ch_next;
    logic [ROUND_W-1:0]  round_reg, round_next;
    logic [CFG_W-1:0]    cfg_reg, cfg_next;
    logic                out_valid_reg, out_valid_next;
    result_t             out_reg, out_next;

    logic                   pop;
    logic [CH_W-1:0]        ridx;
    logic [CH_W-1:0]        sel_idx;
    logic [SAMPLE_BITS-1:0] smp;
    logic [SUM_BITS:0]      sum_ext;
    logic [SUM_BITS-1:0]    sum_sat;
    logic [CH_CMP_W-1:0]    active;
    logic                   wrap;

    assign cfg_ready = 1'b1;
    assign pop       = q_valid && (!out_valid_reg || m_tready);
    assign q_ready   = pop;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_reg;

    // Datapath for the item at the head of the queue
    always_comb
    begin
        sel_idx = CH_W'(q_item.sel);
        ridx    = (q_item.op == OP_SAMPLE) ? cur_ch_reg : sel_idx;
        smp     = SAMPLE_BITS'(q_item.sample);
        sum_ext = {1'b0, live_sum_reg[ridx]} + (SUM_BITS + 1)'(smp);
        sum_sat = sum_ext[SUM_BITS] ? '1 : sum_ext[SUM_BITS-1:0];
        if (cfg_reg == '0)
            active = CH_CMP_W'(1);
        else if (CH_CMP_W'(cfg_reg) > CH_CMP_W'(NUM_CHANNELS))
            active = CH_CMP_W'(NUM_CHANNELS);
        else
            active = CH_CMP_W'(cfg_reg);
        wrap = (CH_CMP_W'(ridx) + 1'b1) >= active;
    end

    always_comb
    begin
        live_min_next = live_min_reg;
        live_max_next = live_max_reg;
        live_sum_next = live_sum_reg;
        live_cnt_next = live_cnt_reg;
        snap_min_next = snap_min_reg;
        snap_max_next = snap_max_reg;
        snap_sum_next = snap_sum_reg;
        snap_cnt_next = snap_cnt_reg;
        latest_next   = latest_reg;
        cur_ch_next   = cur_ch_reg;
        round_next    = round_reg;
        cfg_next      = (cfg_valid && cfg_ready) ? cfg_data : cfg_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        if (pop)
        begin
            out_valid_next = 1'b1;
            out_next       = '0;
            case (q_item.op)
                OP_SAMPLE:
                begin
                    if (smp > live_max_reg[ridx])
                        live_max_next[ridx] = smp;
                    if (smp < live_min_reg[ridx])
                        live_min_next[ridx] = smp;
                    live_sum_next[ridx] = sum_sat;
                    if (live_cnt_reg[ridx] != '1)
                        live_cnt_next[ridx] = live_cnt_reg[ridx] + 1'b1;
                    latest_next[ridx] = smp;
                    if (wrap)
                    begin
                        cur_ch_next = '0;
                        if (round_reg != '1)
                            round_next = round_reg + 1'b1;
                    end
                    else
                    begin
                        cur_ch_next = ridx + 1'b1;
                    end
                end
                OP_BOUNDARY:
                begin
                    out_next.rounds_per_second = round_reg;
                    for (int n = 0; n < NUM_CHANNELS; n++)
                    begin
                        snap_min_next[n] = live_min_reg[n];
                        snap_max_next[n] = live_max_reg[n];
                        snap_sum_next[n] = live_sum_reg[n];
                        snap_cnt_next[n] = live_cnt_reg[n];
                        live_min_next[n] = '1;
                        live_max_next[n] = '0;
                        live_sum_next[n] = '0;
                        live_cnt_next[n] = '0;
                    end
                    round_next = '0;
                end
                OP_READ_SNAP:
                begin
                    if (q_item.sel_ok)
                    begin
                        out_next.stat_min   = SAMPLE_FIELD_W'(snap_min_reg[sel_idx]);
                        out_next.stat_max   = SAMPLE_FIELD_W'(snap_max_reg[sel_idx]);
                        out_next.stat_sum   = SUM_FIELD_W'(snap_sum_reg[sel_idx]);
                        out_next.stat_count = COUNT_FIELD_W'(snap_cnt_reg[sel_idx]);
                    end
                end
                OP_READ_LIVE:
                begin
                    if (q_item.sel_ok)
                    begin
                        out_next.stat_count  = COUNT_FIELD_W'(live_cnt_reg[ridx]);
                        out_next.last_sample = SAMPLE_FIELD_W'(latest_reg[sel_idx]);
                    end
                end
                default:
                begin
                    out_next.pad = 1'b0;
                end
            endcase
            out_next.next_channel = NEXT_CH_W'(cur_ch_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < NUM_CHANNELS; n++)
            begin
                live_min_reg[n] <= '1;
                live_max_reg[n] <= '0;
                live_sum_reg[n] <= '0;
                live_cnt_reg[n] <= '0;
                snap_min_reg[n] <= '0;
                snap_max_reg[n] <= '0;
                snap_sum_reg[n] <= '0;
                snap_cnt_reg[n] <= '0;
                latest_reg[n]   <= '0;
            end
            cur_ch_reg    <= '0;
            round_reg     <= '0;
            cfg_reg       <= CFG_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            live_min_reg  <= live_min_next;
            live_max_reg  <= live_max_next;
            live_sum_reg  <= live_sum_next;
            live_cnt_reg  <= live_cnt_next;
            snap_min_reg  <= snap_min_next;
            snap_max_reg  <= snap_max_next;
            snap_sum_reg  <= snap_sum_next;
            snap_cnt_reg  <= snap_cnt_next;
            latest_reg    <= latest_next;
            cur_ch_reg    <= cur_ch_next;
            round_reg     <= round_next;
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    // Round-robin index always names an existing channel
    a_cur_range: assert property (@(posedge clk) disable iff (!rst_n)
        CH_CMP_W'(cur_ch_reg) < CH_CMP_W'(NUM_CHANNELS))
        else $error("current channel beyond channel count");

    // A boundary clears the round counter and the live set
    a_boundary_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && q_item.op == OP_BOUNDARY) |=>
            (round_reg == '0 && live_cnt_reg[0] == '0 && live_min_reg[0] == '1))
        else $error("live statistics not cleared after boundary");

    // Every executed item leaves a result in the output register
    a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> out_valid_reg)
        else $error("executed item produced no result");

endmodule
